// ===== sv/dcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcd_pkg;

   // Default sizes, handed to the top-level parameters
   localparam int DICT_DEPTH_DEF = 4096;
   localparam int MAX_STRING_DEF = 29;

   // Fixed field widths
   localparam int CODE_W = 12;
   localparam int CHAR_W = 8;
   localparam int LINK_W = 15;

   // Link value that ends a chain
   localparam logic [LINK_W-1:0] END_LINK = 15'h7FFF;

   // Opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   // Command queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic              opcode;
      logic [CODE_W-1:0] entry_index;
      logic [CHAR_W-1:0] entry_char;
      logic [LINK_W-1:0] entry_link;
      logic [CHAR_W-1:0] data_byte;
      logic              packet_last;
   } dcd_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              code_last;
      logic              packet_end;
      logic              chain_overflow;
   } dcd_rsp_type;

   // One classified command, front to back
   typedef struct packed {
      logic              is_load;
      logic              has_code;
      logic              pkt_last;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      logic              end_mark;
      logic [CODE_W-1:0] link;
   } dcd_cmd_type;

   // One dictionary entry
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              end_mark;
      logic [CODE_W-1:0] link;
   } dcd_entry_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } dcd_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT,
      ST_MARK
   } dcd_state_type;

endpackage

`default_nettype wire

// ===== sv/dcd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  dcd_pkg::dcd_req_type req_data,
   output logic                 q_push,
   output dcd_pkg::dcd_cmd_type q_cmd,
   input  wire                  q_ready
);
   import dcd_pkg::*;

   dcd_phase_type     phase_ff, phase_in;
   logic [CHAR_W-1:0] held_ff, held_in;
   logic              accept;
   logic              is_data;
   logic              has_code;
   logic [CODE_W-1:0] code;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign is_data   = (req_data.opcode == OP_DATA);

   // Unpack two 12-bit codes from three bytes
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      has_code = 1'b0;
      code     = '0;
      unique case (phase_ff)
         PH_FIRST: begin
            held_in  = req_data.data_byte;
            phase_in = PH_SECOND;
         end
         PH_SECOND: begin
            code     = {held_ff, req_data.data_byte[7:4]};
            held_in  = {4'b0, req_data.data_byte[3:0]};
            has_code = 1'b1;
            phase_in = PH_THIRD;
         end
         PH_THIRD: begin
            code     = {held_ff[3:0], req_data.data_byte};
            held_in  = '0;
            has_code = 1'b1;
            phase_in = PH_FIRST;
         end
         default: begin
            phase_in = PH_FIRST;
            held_in  = '0;
         end
      endcase
      // Drop partial bits at the end of a packet
      if (req_data.packet_last) begin
         phase_in = PH_FIRST;
         held_in  = '0;
      end
   end

   // Build the command; loads go through the queue to keep order with walks
   always_comb begin
      q_cmd = '0;
      if (is_data) begin
         q_cmd.has_code = has_code;
         q_cmd.pkt_last = req_data.packet_last;
         q_cmd.code     = code;
      end else begin
         q_cmd.is_load  = 1'b1;
         q_cmd.code     = req_data.entry_index;
         q_cmd.ch       = req_data.entry_char;
         q_cmd.end_mark = (req_data.entry_link == END_LINK);
         q_cmd.link     = req_data.entry_link[CODE_W-1:0];
      end
      q_push = accept && (!is_data || has_code || req_data.packet_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         held_ff  <= '0;
      end else if (accept && is_data) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dcd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcd_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  dcd_pkg::dcd_cmd_type push_cmd,
   output logic                 push_ready,
   input  wire                  pop,
   output logic                 pop_valid,
   output dcd_pkg::dcd_cmd_type pop_cmd
);
   import dcd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   dcd_cmd_type   slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dcd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcd_back #(
   parameter int DICT_DEPTH = dcd_pkg::DICT_DEPTH_DEF,
   parameter int MAX_STRING = dcd_pkg::MAX_STRING_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   input  dcd_pkg::dcd_cmd_type q_cmd,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output dcd_pkg::dcd_rsp_type rsp_data
);
   import dcd_pkg::*;

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int NW = $clog2(MAX_STRING + 1);
   localparam logic [CODE_W:0] DEPTH_L = (CODE_W+1)'(DICT_DEPTH);

   dcd_entry_type     dict_mem [DICT_DEPTH];
   dcd_entry_type     rd_ff;
   logic              oob_ff, oob_in;
   logic              rd_en;
   logic [CODE_W-1:0] rd_addr;
   logic              mem_we;

   logic [CHAR_W-1:0] stack_ff [MAX_STRING];
   logic              push;
   logic              pop;

   dcd_state_type     state_ff, state_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [NW-1:0]     drop_ff, drop_in;
   logic [NW-1:0]     emit_cnt_ff, emit_cnt_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   dcd_rsp_type       rsp_ff, rsp_in;
   logic              rsp_load;
   logic              out_free;

   logic [CHAR_W-1:0] walk_char;
   logic              walk_end;
   logic [NW-1:0]     n_next;
   logic [NW-1:0]     drop_next;
   logic              walk_full;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // An entry beyond the depth reads as character zero with the end mark
   assign walk_char = oob_ff ? '0 : rd_ff.ch;
   assign walk_end  = oob_ff || rd_ff.end_mark;
   assign n_next    = n_ff + NW'(1);
   assign walk_full = (n_next == NW'(MAX_STRING));
   // The latest zero seen on the walk is the first one in forward order
   assign drop_next = (walk_char == '0) ? n_next : drop_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !q_cmd.is_load) begin
               state_in = q_cmd.has_code ? ST_WALK : ST_MARK;
            end
         end
         ST_WALK: begin
            if (walk_end || walk_full) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_cnt_ff == '0) begin
               state_in = last_ff ? ST_MARK : ST_IDLE;
            end else if (out_free && (emit_cnt_ff == NW'(1))) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls
   always_comb begin
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      oob_in      = oob_ff;
      push        = 1'b0;
      pop         = 1'b0;
      n_in        = n_ff;
      drop_in     = drop_ff;
      emit_cnt_in = emit_cnt_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               if (q_cmd.is_load) begin
                  mem_we = ({1'b0, q_cmd.code} < DEPTH_L);
               end else begin
                  last_in = q_cmd.pkt_last;
                  ovf_in  = 1'b0;
                  n_in    = '0;
                  drop_in = '0;
                  rd_en   = q_cmd.has_code;
                  rd_addr = q_cmd.code;
                  oob_in  = ({1'b0, q_cmd.code} >= DEPTH_L);
               end
            end
         end
         ST_WALK: begin
            push        = 1'b1;
            n_in        = n_next;
            drop_in     = drop_next;
            emit_cnt_in = n_next - drop_next;
            ovf_in      = !walk_end;
            if (!walk_end && !walk_full) begin
               rd_en   = 1'b1;
               rd_addr = rd_ff.link;
               oob_in  = ({1'b0, rd_ff.link} >= DEPTH_L);
            end
         end
         ST_EMIT: begin
            if ((emit_cnt_ff != '0) && out_free) begin
               rsp_load              = 1'b1;
               pop                   = 1'b1;
               rsp_in.out_char       = stack_ff[0];
               rsp_in.char_valid     = 1'b1;
               rsp_in.code_last      = (emit_cnt_ff == NW'(1));
               rsp_in.packet_end     = last_ff && (emit_cnt_ff == NW'(1));
               rsp_in.chain_overflow = ovf_ff;
               emit_cnt_in           = emit_cnt_ff - NW'(1);
            end
         end
         ST_MARK: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_in.out_char       = '0;
               rsp_in.char_valid     = 1'b0;
               rsp_in.code_last      = 1'b0;
               rsp_in.packet_end     = 1'b1;
               rsp_in.chain_overflow = ovf_ff;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         drop_ff      <= '0;
         emit_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         oob_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         drop_ff      <= drop_in;
         emit_cnt_ff  <= emit_cnt_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         oob_ff       <= oob_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Dictionary: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dict_mem[q_cmd.code[AW-1:0]] <= '{ch: q_cmd.ch, end_mark: q_cmd.end_mark,
                                           link: q_cmd.link};
      end
      if (rd_en) begin
         rd_ff <= dict_mem[rd_addr[AW-1:0]];
      end
   end

   // Reverse stack as a shift line: push at the top, pop from the top
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[0] <= walk_char;
         for (int i = 1; i < MAX_STRING; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < MAX_STRING - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/dictionary_chain_decompressor.sv =====
// Dictionary chain decompressor: static-dictionary 12-bit code decode.
// req channel (valid/ready, dcd_req_type): opcode 0 writes one dictionary
//   entry (character plus link to the previous entry, 0x7FFF ends a chain);
//   opcode 1 carries one byte of a stream packing two 12-bit codes in three
//   bytes. packet_last drops any partial code and ends the packet.
// rsp channel (valid/ready, dcd_rsp_type): the characters of each code, first
//   to last, code_last on the final one; a packet_last byte that yields no
//   character gives one bare marker word with packet_end set.
// A four-entry command queue separates the byte unpacker from the chain
//   walker, so the input keeps flowing while a chain is walked or emitted.
// Timing: the back end writes a load when it pops it from the queue. A
//   code walks n entries (n <= MAX_STRING) at one dictionary read per cycle,
//   each read depending on the last, then emits one character per cycle while
//   rsp_ready is high. The back end pops the next command only once it has
//   finished the code, including any marker word.
// A stalled receiver holds the current rsp word and freezes emission; the
//   queue then fills and req_ready drops.
// Reset clears the byte phase, the queue and the controller; the dictionary
//   is not cleared and must be loaded before codes refer to it.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_chain_decompressor #(
   parameter int DICT_DEPTH = dcd_pkg::DICT_DEPTH_DEF,
   parameter int MAX_STRING = dcd_pkg::MAX_STRING_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  dcd_pkg::dcd_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output dcd_pkg::dcd_rsp_type rsp_data
);
   import dcd_pkg::*;

   logic        q_push;
   logic        q_ready;
   dcd_cmd_type q_in_cmd;
   logic        q_pop;
   logic        q_valid;
   dcd_cmd_type q_out_cmd;

   // Unpack bytes into codes and classify
   dcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_cmd     (q_in_cmd),
      .q_ready   (q_ready)
   );

   // Decouple front and back
   dcd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_out_cmd)
   );

   // Walk chains and emit characters
   dcd_back #(
      .DICT_DEPTH (DICT_DEPTH),
      .MAX_STRING (MAX_STRING)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_out_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("command pushed into a full queue");

   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result word valid right after reset");

   a_marker_ends_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.char_valid) |-> (rsp_data.packet_end && !rsp_data.code_last))
      else $error("bare marker without packet end");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import dcd_pkg::*;

   localparam int MAX_CHARS = MAX_STRING_DEF;
   localparam int DICT_ENTRIES = DICT_DEPTH_DEF;
   localparam int TOTAL_WORDS = 480;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 2 * MAX_CHARS + 40;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      dcd_req_type word;
      int          typed_count;   // -1: take the decoded prediction
      dcd_rsp_type typed_a;
      dcd_rsp_type typed_b;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dcd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dcd_rsp_type rsp_data;

   // Shadow dictionary and byte unpacker state
   logic [CHAR_W-1:0] dict_char [DICT_ENTRIES];
   logic              dict_end [DICT_ENTRIES];
   logic [CODE_W-1:0] dict_prev [DICT_ENTRIES];
   bit                dict_loaded [DICT_ENTRIES];
   logic [CODE_W-1:0] loaded_list [$];
   logic [CODE_W-1:0] newest_entry = '0;
   dcd_phase_type     byte_phase = PH_FIRST;
   logic [CHAR_W-1:0] held_byte = '0;

   // Characters decoded from the latest word, and all still owed by the block
   dcd_rsp_type step_words [MAX_CHARS];
   int          step_count;
   dcd_rsp_type pending_chars [$];
   dcd_rsp_type oldest_word;

   directed_row_type directed_rows [$];
   int  words_sent = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  idle_on = 1'b1;
   bit  hold_request = 1'b0;

   dictionary_chain_decompressor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic dcd_rsp_type rsp_word(input logic [CHAR_W-1:0] ch, input logic valid,
                                            input logic clast, input logic pend,
                                            input logic ovf);
      dcd_rsp_type r;
      r.out_char = ch;
      r.char_valid = valid;
      r.code_last = clast;
      r.packet_end = pend;
      r.chain_overflow = ovf;
      return r;
   endfunction

   // Build a load word; the byte fields are ignored, so fill them at random
   function automatic dcd_req_type load_word(input logic [CODE_W-1:0] idx,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic [LINK_W-1:0] link);
      dcd_req_type w;
      w.opcode = OP_LOAD;
      w.entry_index = idx;
      w.entry_char = ch;
      w.entry_link = link;
      w.data_byte = 8'($urandom_range(0, 255));
      w.packet_last = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // Build a data word; the entry fields are ignored, so fill them at random
   function automatic dcd_req_type data_word(input logic [CHAR_W-1:0] data,
                                             input logic last);
      dcd_req_type w;
      w.opcode = OP_DATA;
      w.entry_index = 12'($urandom_range(0, 4095));
      w.entry_char = 8'($urandom_range(0, 255));
      w.entry_link = 15'($urandom_range(0, 32767));
      w.data_byte = data;
      w.packet_last = last;
      return w;
   endfunction

   function automatic void add_row(input dcd_req_type w, input int n,
                                   input dcd_rsp_type a, input dcd_rsp_type b);
      directed_row_type row;
      row.word = w;
      row.typed_count = n;
      row.typed_a = a;
      row.typed_b = b;
      directed_rows.push_back(row);
   endfunction

   // Pick a code whose whole chain has been loaded
   function automatic logic [CODE_W-1:0] pick_code();
      if ($urandom_range(0, 9) < 3)
         return newest_entry;
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   // Decode one accepted word into step_words
   task automatic predict_word(input dcd_req_type w);
      logic [CODE_W-1:0] walk_idx;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] walk_chars [MAX_CHARS];
      bit                has_code;
      bit                overflow;
      int                depth;
      int                k;
      step_count = 0;
      if (w.opcode == OP_LOAD) begin
         // store the entry; only the full end value marks the chain end
         dict_char[w.entry_index] = w.entry_char;
         dict_end[w.entry_index] = (w.entry_link == END_LINK);
         dict_prev[w.entry_index] = w.entry_link[CODE_W-1:0];
         if (!dict_loaded[w.entry_index])
            loaded_list.push_back(w.entry_index);
         dict_loaded[w.entry_index] = 1'b1;
         newest_entry = w.entry_index;
         return;
      end
      // unpack two codes from three bytes, high bits first
      has_code = 1'b1;
      code = '0;
      case (byte_phase)
         PH_FIRST: begin
            held_byte = w.data_byte;
            byte_phase = PH_SECOND;
            has_code = 1'b0;
         end
         PH_SECOND: begin
            code = {held_byte, w.data_byte[7:4]};
            held_byte = {4'h0, w.data_byte[3:0]};
            byte_phase = PH_THIRD;
         end
         default: begin
            code = {held_byte[3:0], w.data_byte};
            held_byte = '0;
            byte_phase = PH_FIRST;
         end
      endcase
      overflow = 1'b0;
      if (has_code) begin
         // walk back toward the end mark, nearest character first
         depth = 0;
         walk_idx = code;
         forever begin
            if (depth == MAX_CHARS) begin
               overflow = 1'b1;
               break;
            end
            walk_chars[depth] = dict_char[walk_idx];
            depth++;
            if (dict_end[walk_idx])
               break;
            walk_idx = dict_prev[walk_idx];
         end
         // emit first to last, drop everything from the first zero on
         for (k = depth - 1; k >= 0; k--) begin
            if (walk_chars[k] == 8'h00)
               break;
            step_words[step_count] = rsp_word(walk_chars[k], 1'b1, 1'b0, 1'b0, overflow);
            step_count++;
         end
         if (step_count > 0)
            step_words[step_count - 1].code_last = 1'b1;
      end
      // end of packet: drop partial bits, mark the last word
      if (w.packet_last) begin
         byte_phase = PH_FIRST;
         held_byte = '0;
         if (step_count > 0) begin
            step_words[step_count - 1].packet_end = 1'b1;
         end else begin
            step_words[0] = rsp_word(8'h00, 1'b0, 1'b0, 1'b1, overflow);
            step_count = 1;
         end
      end
   endtask

   // Offer one word; entered and left just after a falling edge
   task automatic offer_word(input dcd_req_type w, input int n,
                             input dcd_rsp_type a, input dcd_rsp_type b);
      int gap;
      int k;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predict_word(w);
      if (n < 0) begin
         for (k = 0; k < step_count; k++)
            pending_chars.push_back(step_words[k]);
      end else begin
         if (n > 0)
            pending_chars.push_back(a);
         if (n > 1)
            pending_chars.push_back(b);
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic load_random(input bit extend);
      logic [CODE_W-1:0] idx;
      logic [CHAR_W-1:0] ch;
      logic [LINK_W-1:0] link;
      int                r;
      r = $urandom_range(0, 9);
      if (r == 0)
         idx = 12'h000;
      else if (r == 1)
         idx = 12'hFFF;
      else if (r < 4)
         idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      else
         idx = 12'($urandom_range(0, 4095));
      r = $urandom_range(0, 39);
      if (r == 0)
         ch = 8'h00;
      else if (r == 1)
         ch = 8'hFF;
      else
         ch = 8'($urandom_range(1, 255));
      // link only to loaded entries so no walk leaves the loaded set
      if (!extend && $urandom_range(0, 3) == 0) begin
         link = END_LINK;
      end else begin
         link[CODE_W-1:0] = extend ? newest_entry
                                   : loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         link[LINK_W-1:CODE_W] = 3'($urandom_range(0, 7));
      end
      offer_word(load_word(idx, ch, link), -1, '0, '0);
   endtask

   task automatic send_packet();
      logic [CODE_W-1:0] first_code;
      logic [CODE_W-1:0] second_code;
      int                code_total;
      int                k;
      bit                trailing;
      if ($urandom_range(0, 9) == 0) begin
         // lone byte ends the packet before any code
         offer_word(data_word(8'($urandom_range(0, 255)), 1'b1), -1, '0, '0);
         return;
      end
      code_total = $urandom_range(1, 4);
      trailing = (code_total % 2 == 0) && ($urandom_range(0, 5) == 0);
      for (k = 0; k < code_total; k += 2) begin
         first_code = pick_code();
         offer_word(data_word(first_code[11:4], 1'b0), -1, '0, '0);
         if (k + 1 < code_total) begin
            second_code = pick_code();
            offer_word(data_word({first_code[3:0], second_code[11:8]}, 1'b0), -1, '0, '0);
            offer_word(data_word(second_code[7:0], (k + 2 >= code_total) && !trailing),
                       -1, '0, '0);
         end else begin
            // odd count: end on the middle byte, its low nibble is dropped
            offer_word(data_word({first_code[3:0], 4'($urandom_range(0, 15))}, 1'b1),
                       -1, '0, '0);
         end
      end
      // held byte dropped by an early packet end
      if (trailing)
         offer_word(data_word(8'($urandom_range(0, 255)), 1'b1), -1, '0, '0);
   endtask

   task automatic report_error(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h, expected %0h", field, got, want));
   endtask

   task automatic check_flag(input string field, input logic got, input logic want);
      if (got !== want)
         report_error($sformatf("%s got %0b, expected %0b", field, got, want));
   endtask

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            report_error($sformatf("unexpected word, char %0h", rsp_data.out_char));
         end else begin
            oldest_word = pending_chars.pop_front();
            check_field("out_char", rsp_data.out_char, oldest_word.out_char);
            check_flag("char_valid", rsp_data.char_valid, oldest_word.char_valid);
            check_flag("code_last", rsp_data.code_last, oldest_word.code_last);
            check_flag("packet_end", rsp_data.packet_end, oldest_word.packet_end);
            check_flag("chain_overflow", rsp_data.chain_overflow,
                       oldest_word.chain_overflow);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: short random stalls, and one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall_left = LONG_HOLD;
            hold_request = 1'b0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   initial begin : stimulus
      int pick;
      int run;
      // loads: plain, extreme index, masked link, self loops
      add_row(load_word(12'h000, 8'h41, END_LINK), 0, '0, '0);
      add_row(load_word(12'hFFF, 8'hFF, END_LINK), 0, '0, '0);
      add_row(load_word(12'h001, 8'h01, 15'h0000), 0, '0, '0);
      add_row(load_word(12'h002, 8'h00, 15'h0001), 0, '0, '0);
      add_row(load_word(12'h003, 8'h42, 15'h0002), 0, '0, '0);
      add_row(load_word(12'h005, 8'h00, END_LINK), 0, '0, '0);
      add_row(load_word(12'h006, 8'h43, 15'h7000), 0, '0, '0);
      add_row(load_word(12'h007, 8'h44, 15'h0007), 0, '0, '0);
      add_row(load_word(12'h008, 8'h00, 15'h0008), 0, '0, '0);
      // codes 0 and 4095
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h0F, 1'b0), 1, rsp_word(8'h41, 1'b1, 1'b1, 1'b0, 1'b0), '0);
      add_row(data_word(8'hFF, 1'b0), 1, rsp_word(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0), '0);
      // codes 1 and 3: the second stops at its zero character
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h10, 1'b0), 2, rsp_word(8'h41, 1'b1, 1'b0, 1'b0, 1'b0),
              rsp_word(8'h01, 1'b1, 1'b1, 1'b0, 1'b0));
      add_row(data_word(8'h03, 1'b1), 2, rsp_word(8'h41, 1'b1, 1'b0, 1'b0, 1'b0),
              rsp_word(8'h01, 1'b1, 1'b1, 1'b1, 1'b0));
      // empty code, then a looping chain cut at full length
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h50, 1'b0), 0, '0, '0);
      add_row(data_word(8'h07, 1'b1), -1, '0, '0);
      // packet ends on the middle byte, nibble dropped
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h6F, 1'b1), 2, rsp_word(8'h41, 1'b1, 1'b0, 1'b0, 1'b0),
              rsp_word(8'h43, 1'b1, 1'b1, 1'b1, 1'b0));
      // packet ends on a held byte: bare marker
      add_row(data_word(8'hAB, 1'b1), 1, rsp_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b0), '0);
      // cut chain of zeros: bare marker with the overflow flag
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h8A, 1'b1), 1, rsp_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1), '0);
      // empty code on the last byte after a full pair
      add_row(data_word(8'h00, 1'b0), 0, '0, '0);
      add_row(data_word(8'h00, 1'b0), 1, rsp_word(8'h41, 1'b1, 1'b1, 1'b0, 1'b0), '0);
      add_row(data_word(8'h05, 1'b1), 1, rsp_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b0), '0);

      // hold reset, then release on a falling edge
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[row])
         offer_word(directed_rows[row].word, directed_rows[row].typed_count,
                    directed_rows[row].typed_a, directed_rows[row].typed_b);

      // refill the zero entries so random chains stay mostly printable
      offer_word(load_word(12'h002, 8'h5A, 15'h0001), -1, '0, '0);
      offer_word(load_word(12'h005, 8'h61, END_LINK), -1, '0, '0);
      offer_word(load_word(12'h008, 8'h7E, 15'h0008), -1, '0, '0);

      while (words_sent < TOTAL_WORDS) begin
         idle_on = !((words_sent >= 220 && words_sent < 300) || words_sent >= 400);
         if (words_sent >= 45 && words_sent < 50)
            hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // grow one long chain
            run = $urandom_range(2, 34);
            repeat (run) load_random(1'b1);
         end else if (pick < 35) begin
            load_random(1'b0);
         end else begin
            send_packet();
         end
      end
      req_valid <= 1'b0;

      // drain, then give stray words time to show up
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
